// ===== rtl/prs_pkg.sv =====
// Shared types, constants and helpers for the particle repulsion step block.
package prs_pkg;

  localparam int unsigned MaxParticles = 64;
  localparam int unsigned IdxW = $clog2(MaxParticles);
  localparam int unsigned CntW = $clog2(MaxParticles + 1);

  // Action codes
  localparam logic [1:0] ActSpawn = 2'd0;
  localparam logic [1:0] ActStep  = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  // Status codes
  localparam logic [2:0] StSpawned = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StStepped = 3'd2;
  localparam logic [2:0] StReadOk  = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;

  // Register indexes
  localparam logic [1:0] RegRadius  = 2'd0;
  localparam logic [1:0] RegGravity = 2'd1;
  localparam logic [1:0] RegDamping = 2'd2;
  localparam logic [1:0] RegLife    = 2'd3;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    return r;
  endfunction

  // Divider request / response between top and divide unit
  typedef struct packed {
    logic               start;
    logic signed [33:0] num_hi; // dividend is num_hi * 65536
    logic [32:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [50:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/prs_sqrt.sv =====
// Iterative integer square root: each step consumes two radicand bits and yields one root bit.
module prs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] val_i,
  output logic        done_o,
  output logic [32:0] root_o
);
  logic [65:0] n_q, n_d;
  logic [65:0] root_q, root_d;
  logic [65:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  // One digit per cycle, restoring form
  always_comb begin
    n_d = n_q; root_d = root_q; bit_d = bit_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      n_d = val_i; root_d = '0; bit_d = 66'd1 << 64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (n_q >= root_q + bit_q) begin
        n_d = n_q - (root_q + bit_q);
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; root_q <= root_d; bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[32:0];
endmodule

// ===== rtl/prs_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module prs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prs_pkg::div_req_t req_i,
  output prs_pkg::div_rsp_t rsp_o
);
  localparam int unsigned NW = 50;
  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [33:0]   rem_q, rem_d;
  logic [32:0]   den_q, den_d;
  logic          neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [33:0]   mag;
  logic [34:0]   trial;

  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    mag = req_i.num_hi[33] ? 34'(-req_i.num_hi) : 34'(req_i.num_hi);
    trial = {rem_q, num_q[NW-1]} - {2'b0, den_q};
    if (req_i.start) begin
      num_d = {mag, 16'h0}; quo_d = '0; rem_d = '0; den_d = req_i.den;
      neg_d = req_i.num_hi[33]; cnt_d = 6'(NW - 1); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_d = trial[33:0]; quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], num_q[NW-1]}; quo_d = {quo_q[NW-2:0], 1'b0};
      end
      num_d = {num_q[NW-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
    neg_q <= neg_d; cnt_q <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ===== rtl/particle_repulsion_step.sv =====
// Top level: particle store in a memory with a sequenced step engine.
//
// Channel | dir | handshake          | contents
// s_axis  | in  | tvalid/tready      | action, spawn fields, slot
// m_axis  | out | tvalid/tready      | status, count, read particle
// cfg     | in  | cfg_we_i           | four registers by index
//
// A spawn, a full-store spawn, a step on an empty store and an empty-slot read
// give their result the cycle after the beat is taken; a read of a held slot
// passes through S_RDWT first. For each particle i a step runs S_IRD, S_IUPD
// and S_DAMP, then S_JRD and S_JCHK for each j to read and range-check j (a
// pair in range adds the serial root and two serial divides), then S_OUT.
// Reset clears the count and sets the config to its defaults; stores are undefined until written.
// A waiting result holds the engine; input is taken only when idle.
module particle_repulsion_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] action, [13:2] spawn_x, [25:14] spawn_y, [33:26] spawn_vx,
  // [41:34] spawn_vy, [65:42] spawn_rgb, [71:66] slot
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [9:3] particle_count, [41:10] out_x, [73:42] out_y,
  // [81:74] out_alpha, [105:82] out_rgb
  output logic [111:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);
  localparam int unsigned IW = prs_pkg::IdxW;
  localparam int unsigned CW = prs_pkg::CntW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RDWT  = 11'b00000000010,
    S_IRD   = 11'b00000000100,
    S_IUPD  = 11'b00000001000,
    S_DAMP  = 11'b00000010000,
    S_JRD   = 11'b00000100000,
    S_JCHK  = 11'b00001000000,
    S_SQRT  = 11'b00010000000,
    S_DIVX  = 11'b00100000000,
    S_DIVY  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [9:0]  radius_q;
  logic [15:0] gravity_q;
  logic [16:0] damping_q;
  logic [7:0]  ilife_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 10'd50; gravity_q <= 16'd3277;
      damping_q <= 17'd64880; ilife_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prs_pkg::RegRadius:  radius_q  <= cfg_wdata_i[9:0];
        prs_pkg::RegGravity: gravity_q <= cfg_wdata_i[15:0];
        prs_pkg::RegDamping: damping_q <= cfg_wdata_i;
        prs_pkg::RegLife:    ilife_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Particle store: one wide memory, one write and one registered read port
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [7:0]         life;
    logic [23:0]        rgb;
  } part_t;

  part_t          mem [prs_pkg::MaxParticles];
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  part_t          wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Datapath registers
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      i_q, i_d, j_q, j_d;
  part_t              cur_q, cur_d;
  logic signed [63:0] prodx_q, prodx_d, prody_q, prody_d;
  logic signed [33:0] dx_q, dx_d, dy_q, dy_d;
  logic [32:0]        dist_q, dist_d;
  logic [111:0]       out_q, out_d;
  logic               ovld_q, ovld_d;

  // Pair distance check
  logic signed [33:0] dxw, dyw;
  logic [32:0]        adx, ady, lim;
  logic [65:0]        d2, lim2;
  logic               sq_start, sq_done, in_range;
  logic [32:0]        sq_root;
  prs_pkg::div_req_t  dreq;
  prs_pkg::div_rsp_t  drsp;
  logic signed [33:0] vadd;

  prs_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(d2),
    .done_o(sq_done), .root_o(sq_root)
  );

  prs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic signed [33:0] dpx, dpy;
  logic signed [63:0] pxm, pym;

  always_comb begin
    dxw = 34'(cur_q.px) - 34'(rdata_q.px);
    dyw = 34'(cur_q.py) - 34'(rdata_q.py);
    adx = dxw[33] ? 33'(-dxw) : 33'(dxw);
    ady = dyw[33] ? 33'(-dyw) : 33'(dyw);
    lim = {7'd0, radius_q, 16'd0};
    d2  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
    lim2 = 66'(lim) * 66'(lim);
    in_range = (adx < lim) && (ady < lim) && (d2 != '0) && (d2 < lim2);
  end

  // Floor of the damped product: arithmetic shift already floors
  always_comb begin
    pxm = prodx_q >>> 16;
    pym = prody_q >>> 16;
    dpx = 34'(pxm);
    dpy = 34'(pym);
  end

  always_comb begin
    state_d = state_q; count_d = count_q; i_d = i_q; j_d = j_q;
    cur_d = cur_q; prodx_d = prodx_q; prody_d = prody_q;
    dx_d = dx_q; dy_d = dy_q; dist_d = dist_q; out_d = out_q;
    ovld_d = ovld_q;
    we = 1'b0; waddr = i_q[IW-1:0]; wdata = cur_q; raddr = i_q[IW-1:0];
    sq_start = 1'b0; dreq = '0; vadd = '0;
    if (ovld_q && m_axis_tready_i) ovld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i && !ovld_q) begin
          case (s_axis_tdata_i[1:0])
            prs_pkg::ActSpawn: begin
              if (count_q >= CW'(prs_pkg::MaxParticles)) begin
                out_d = {102'd0, count_q, prs_pkg::StFull}; ovld_d = 1'b1;
              end else begin
                we = 1'b1; waddr = count_q[IW-1:0];
                wdata.px = {4'd0, s_axis_tdata_i[13:2], 16'd0};
                wdata.py = {4'd0, s_axis_tdata_i[25:14], 16'd0};
                wdata.vx = {{8{s_axis_tdata_i[33]}}, s_axis_tdata_i[33:26], 16'd0};
                wdata.vy = {{8{s_axis_tdata_i[41]}}, s_axis_tdata_i[41:34], 16'd0};
                wdata.life = ilife_q;
                wdata.rgb = s_axis_tdata_i[65:42];
                count_d = count_q + CW'(1);
                out_d = {102'd0, count_d, prs_pkg::StSpawned}; ovld_d = 1'b1;
              end
            end
            prs_pkg::ActStep: begin
              i_d = '0;
              if (count_q == '0) begin
                out_d = {102'd0, count_q, prs_pkg::StStepped}; ovld_d = 1'b1;
              end else begin
                raddr = '0; state_d = S_IRD;
              end
            end
            prs_pkg::ActRead: begin
              if (CW'(s_axis_tdata_i[71:66]) < count_q) begin
                raddr = s_axis_tdata_i[66 +: IW]; state_d = S_RDWT;
              end else begin
                out_d = {102'd0, count_q, prs_pkg::StEmpty}; ovld_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDWT: begin
        out_d = {6'd0, rdata_q.rgb, rdata_q.life, rdata_q.py, rdata_q.px,
                 count_q, prs_pkg::StReadOk};
        ovld_d = 1'b1; state_d = S_IDLE;
      end
      S_IRD: begin
        // gravity, move
        cur_d = rdata_q;
        cur_d.vy = prs_pkg::sat34(34'(rdata_q.vy) + 34'(gravity_q));
        cur_d.px = prs_pkg::sat34(34'(rdata_q.px) + 34'(rdata_q.vx));
        cur_d.py = prs_pkg::sat34(34'(rdata_q.py) + 34'(cur_d.vy));
        if (rdata_q.life != '0) cur_d.life = rdata_q.life - 8'd1;
        state_d = S_IUPD;
      end
      S_IUPD: begin
        prodx_d = 64'(cur_q.vx) * $signed({47'd0, damping_q});
        prody_d = 64'(cur_q.vy) * $signed({47'd0, damping_q});
        // write moved position so later reads see it
        we = 1'b1; state_d = S_DAMP;
      end
      S_DAMP: begin
        cur_d.vx = prs_pkg::sat34(dpx);
        cur_d.vy = prs_pkg::sat34(dpy);
        j_d = '0; raddr = '0; state_d = S_JRD;
      end
      S_JRD: begin
        // read of j issued; data arrives next cycle
        raddr = j_q[IW-1:0];
        state_d = S_JCHK;
      end
      S_JCHK: begin
        dx_d = dxw; dy_d = dyw;
        if (j_q != i_q && in_range) begin
          sq_start = 1'b1; state_d = S_SQRT;
        end else begin
          j_d = j_q + CW'(1);
          if (j_d >= count_q) begin
            we = 1'b1; state_d = S_OUT;
          end else begin
            raddr = j_d[IW-1:0]; state_d = S_JRD;
          end
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          dist_d = (sq_root == '0) ? 33'd1 : sq_root;
          dreq.start = 1'b1; dreq.num_hi = dx_q;
          dreq.den = (sq_root == '0) ? 33'd1 : sq_root;
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        if (drsp.done) begin
          vadd = prs_pkg::sat34(34'(cur_q.vx) + 34'(drsp.quo[33:0]));
          cur_d.vx = (drsp.quo > 51'sd4294967296 || drsp.quo < -51'sd4294967296)
                     ? (drsp.quo[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : vadd[31:0];
          dreq.start = 1'b1; dreq.num_hi = dy_q; dreq.den = dist_q;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (drsp.done) begin
          vadd = prs_pkg::sat34(34'(cur_q.vy) + 34'(drsp.quo[33:0]));
          cur_d.vy = (drsp.quo > 51'sd4294967296 || drsp.quo < -51'sd4294967296)
                     ? (drsp.quo[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : vadd[31:0];
          j_d = j_q + CW'(1);
          if (j_d >= count_q) begin
            we = 1'b1; wdata = cur_d; state_d = S_OUT;
          end else begin
            raddr = j_d[IW-1:0]; state_d = S_JRD;
          end
        end
      end
      S_OUT: begin
        i_d = i_q + CW'(1);
        if (i_d >= count_q) begin
          out_d = {102'd0, count_q, prs_pkg::StStepped}; ovld_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr = i_d[IW-1:0]; state_d = S_IRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; ovld_q <= 1'b0;
      i_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovld_q <= ovld_d;
      i_q <= i_d; j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; prodx_q <= prodx_d; prody_q <= prody_d;
    dx_q <= dx_d; dy_q <= dy_d; dist_q <= dist_d; out_q <= out_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && !ovld_q;
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = out_q;

  // Count never exceeds the store depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(prs_pkg::MaxParticles)) else $error("count overflow");
  // A pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready_i |=> ovld_q && $stable(out_q)) else $error("result lost");
  // Input is taken only while idle
  a_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == S_IDLE) else $error("busy accept");
  // The count only changes on a spawn
  a_count_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q) == S_IDLE) else $error("count change");

endmodule

// ===== test/prs_checker.sv =====
// Result checker for the particle repulsion step block: predicts and compares.
`timescale 1ns / 100ps
module prs_checker
  import prs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [71:0]  in_data_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [111:0] out_data_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [16:0]  cfg_wdata_i,
  output int           errors_o,
  output int           pending_o,
  output int           results_o
);

  // members listed from the top bit down, status in the lowest bits
  typedef struct packed {
    logic [23:0]        rgb;
    logic [7:0]         alpha;
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic [6:0]         count;
    logic [2:0]         status;
  } particle_result_t;

  // predicted particle store
  logic signed [31:0] pos_x [MaxParticles];
  logic signed [31:0] pos_y [MaxParticles];
  logic signed [31:0] vel_x [MaxParticles];
  logic signed [31:0] vel_y [MaxParticles];
  logic [7:0]         life [MaxParticles];
  logic [23:0]        colour [MaxParticles];
  int unsigned        held;
  logic [9:0]         radius;
  logic [15:0]        gravity;
  logic [16:0]        damping;
  logic [7:0]         new_life;

  particle_result_t awaited_results [$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] apply_damping(input logic signed [31:0] v);
    longint p;
    longint q;
    p = longint'(v) * longint'({15'd0, damping});
    if (p >= 0) q = p / 65536;
    else q = -((-p + 65535) / 65536);
    return clamp32(q);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // one whole step over the held particles, in store order, in place
  task automatic advance_all();
    longint lim;
    longint unsigned lim2;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    longint dx;
    longint dy;
    longint adx;
    longint ady;
    longint pair_dist;
    longint unsigned d2;
    lim = longint'(radius) * 65536;
    lim2 = lim * lim;
    for (int i = 0; i < held; i++) begin
      vx = vel_x[i];
      vy = clamp32(longint'(vel_y[i]) + longint'(gravity));
      pos_x[i] = clamp32(longint'(pos_x[i]) + vx);
      pos_y[i] = clamp32(longint'(pos_y[i]) + vy);
      vx = apply_damping(vx);
      vy = apply_damping(vy);
      if (life[i] != 0) life[i]--;
      for (int j = 0; j < held; j++) begin
        if (j == i) continue;
        dx = longint'(pos_x[i]) - longint'(pos_x[j]);
        dy = longint'(pos_y[i]) - longint'(pos_y[j]);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx >= lim || ady >= lim) continue;
        d2 = adx * adx + ady * ady;
        // coincident particles push nothing
        if (d2 == 0 || d2 >= lim2) continue;
        pair_dist = longint'(int_root(d2));
        if (pair_dist < 1) pair_dist = 1;
        vx = clamp32(longint'(vx) + (dx * 65536) / pair_dist);
        vy = clamp32(longint'(vy) + (dy * 65536) / pair_dist);
      end
      vel_x[i] = vx;
      vel_y[i] = vy;
    end
  endtask

  task automatic predict_beat(input logic [71:0] d);
    particle_result_t r;
    logic [5:0] s;
    r = '0;
    s = d[71:66];
    case (d[1:0])
      ActSpawn: begin
        if (held >= MaxParticles) begin
          r.status = StFull;
        end else begin
          pos_x[held]  = {4'd0, d[13:2], 16'd0};
          pos_y[held]  = {4'd0, d[25:14], 16'd0};
          vel_x[held]  = {{8{d[33]}}, d[33:26], 16'd0};
          vel_y[held]  = {{8{d[41]}}, d[41:34], 16'd0};
          life[held]   = new_life;
          colour[held] = d[65:42];
          held++;
          r.status = StSpawned;
        end
      end
      ActStep: begin
        advance_all();
        r.status = StStepped;
      end
      ActRead: begin
        if (s < held) begin
          r.status = StReadOk;
          r.px = pos_x[s];
          r.py = pos_y[s];
          r.alpha = life[s];
          r.rgb = colour[s];
        end else begin
          r.status = StEmpty;
        end
      end
      default: return;  // unused action: no result
    endcase
    r.count = held[6:0];
    awaited_results.insert(awaited_results.size(), r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    particle_result_t got;
    particle_result_t want;
    if (!rst_ni) begin
      held = 0;
      radius = 10'd50;
      gravity = 16'd3277;
      damping = 17'd64880;
      new_life = 8'd255;
      awaited_results.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRadius:  radius = cfg_wdata_i[9:0];
          RegGravity: gravity = cfg_wdata_i[15:0];
          RegDamping: damping = cfg_wdata_i;
          RegLife:    new_life = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      // check the outgoing beat before predicting the incoming one
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[105:0];
        results_o++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.px !== want.px || got.py !== want.py ||
              got.alpha !== want.alpha || got.rgb !== want.rgb) begin
            $display("%0t: mismatch expected st=%0d n=%0d x=%h y=%h a=%0d c=%h",
                     $realtime, want.status, want.count, want.px, want.py,
                     want.alpha, want.rgb);
            $display("%0t:          actual   st=%0d n=%0d x=%h y=%h a=%0d c=%h",
                     $realtime, got.status, got.count, got.px, got.py,
                     got.alpha, got.rgb);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus and verdict for the particle repulsion step block.
`timescale 1ns / 100ps
module testbench;
  import prs_pkg::*;

  localparam longint CycleLimit = 64'd100_000_000;
  // action code with no meaning: taken, no result
  localparam logic [1:0] ActUnused = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [71:0]  s_data = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [111:0] m_data;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = RegRadius;
  logic [16:0]  cfg_wdata = '0;
  int           errors;
  int           pending;
  int           results;
  longint       cycles = 0;
  bit           hold_off = 1'b0;
  int           beats_sent = 0;

  always #5 clk_i = ~clk_i;

  particle_repulsion_step u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  prs_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_ready <= 1'b0;
    else m_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (rst_ni);
    wait (beats_sent >= 60);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic logic [71:0] make_beat(input logic [1:0] act, input logic [11:0] x,
                                            input logic [11:0] y, input logic [7:0] vx,
                                            input logic [7:0] vy, input logic [23:0] rgb,
                                            input logic [5:0] slot);
    return {slot, rgb, vy, vx, y, x, act};
  endfunction

  // valid stays up after a beat when the next follows with no gap
  task automatic send(input logic [71:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_data <= d;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    beats_sent++;
  endtask

  task automatic spawn_rand(input int spread);
    send(make_beat(ActSpawn, 12'(2000 + $urandom_range(0, spread)),
                   12'(2000 + $urandom_range(0, spread)), 8'($urandom),
                   8'($urandom), 24'($urandom), 6'd0));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] v);
    cfg_idx <= idx;
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk_i);
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reset_regs(input logic [9:0] rad, input logic [15:0] grav,
                            input logic [16:0] damp, input logic [7:0] lf);
    settle();
    write_reg(RegRadius, {7'd0, rad});
    write_reg(RegGravity, {1'b0, grav});
    write_reg(RegDamping, damp);
    write_reg(RegLife, {9'd0, lf});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, extremes, coincident pair, unused action
    send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'd0));
    send(make_beat(ActStep, 0, 0, 0, 0, 0, 6'd63));
    send(make_beat(ActSpawn, 12'd0, 12'd0, 8'h80, 8'h80, 24'h000000, 6'd0));
    send(make_beat(ActSpawn, 12'hFFF, 12'hFFF, 8'h7F, 8'h7F, 24'hFFFFFF, 6'd0));
    send(make_beat(ActSpawn, 12'd100, 12'd100, 8'd0, 8'd0, 24'hA5A5A5, 6'd0));
    send(make_beat(ActSpawn, 12'd100, 12'd100, 8'd0, 8'd0, 24'h5A5A5A, 6'd0));
    send(make_beat(ActSpawn, 12'd110, 12'd103, 8'hFF, 8'h01, 24'h123456, 6'd0));
    send(make_beat(ActUnused, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 24'hFFFFFF, 6'd63));
    send(make_beat(ActStep, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 5; k++) send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'(k)));
    send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'd63));

    // extreme settings: wide radius, full gravity, no damping, zero life
    reset_regs(10'd1023, 16'hFFFF, 17'd65536, 8'd0);
    send(make_beat(ActStep, 0, 0, 0, 0, 0, 0));
    send(make_beat(ActStep, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 5; k++) send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'(k)));

    // random: spawns, near each other at first, steps and reads, some noise
    reset_regs(10'd0, 16'd0, 17'd0, 8'd1);
    for (int n = 0; n < 80; n++) begin
      if (n == 25) reset_regs(10'd50, 16'd3277, 17'd64880, 8'd255);
      if (n == 50) reset_regs(10'($urandom_range(1, 1023)), 16'($urandom),
                              17'($urandom_range(0, 131071)), 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 45) spawn_rand(n < 50 ? 60 : 2047);
      else if (r < 55) send(make_beat(ActStep, 0, 0, 0, 0, 0, 6'($urandom)));
      else if (r < 95) send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'($urandom)));
      else send(make_beat(ActUnused, 12'($urandom), 12'($urandom), 8'($urandom),
                          8'($urandom), 24'($urandom), 6'($urandom)));
    end
    // fill the store past full, then a final step and reads
    repeat (40) spawn_rand(4000);
    send(make_beat(ActStep, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 4; k++) send(make_beat(ActRead, 0, 0, 0, 0, 0, 6'($urandom)));

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d input beats and %0d results over spawn, step, read,", beats_sent,
             results);
    $display("store full and empty slot, with four register settings");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
